@@ rtl/twfc_pkg.sv @@
// Shared types, format codes and constants for the tile write format converter.
`timescale 1ns / 1ps

package twfc_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned MAX_COMP_DEF = 4;

  localparam int unsigned FIELD_W = 13;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 26;
  localparam int unsigned QDEPTH = 4;

  localparam logic [FMT_W-1:0] FMT_UNORM8 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_SNORM8 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_HALF = 3'd2;
  localparam logic [FMT_W-1:0] FMT_FLOAT = 3'd3;
  localparam logic [FMT_W-1:0] FMT_INT32 = 3'd4;

  localparam logic [1:0] REG_BUF_WIDTH = 2'd0;
  localparam logic [1:0] REG_BUF_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEST_FORMAT = 2'd2;
  localparam logic [1:0] REG_DEST_COMPS = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
    logic [2:0]         dcomp;
    logic [FMT_W-1:0]   dfmt;
    logic               active;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   base;
    logic [FIELD_W-1:0] x;
    logic [1:0]         comp;
    logic [FMT_W-1:0]   sfmt;
    logic [VAL_W-1:0]   value;
  } q_entry_t;

endpackage

@@ rtl/twfc_front.sv @@
// Front end: tile position tracking, clipping and row base address product.
`timescale 1ns / 1ps

module twfc_front #(
  parameter int unsigned MAX_WIDTH = twfc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = twfc_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_COMPONENTS = twfc_pkg::MAX_COMP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_start_req,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_x0,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_y0,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_width,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_height,
  input  logic [twfc_pkg::FMT_W-1:0]    in_src_format,
  input  logic [2:0]                    in_src_components,
  input  logic [twfc_pkg::VAL_W-1:0]    in_src_value,
  input  twfc_pkg::cfg_t                cfg_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output twfc_pkg::q_entry_t            q_data_o
);
  import twfc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned RW1 = RW + 1;
  localparam int unsigned PW1 = PW + 1;
  localparam int unsigned XW = ((FIELD_W > CW) ? FIELD_W : CW) + 1;
  localparam int unsigned YW = ((FIELD_W > RW) ? FIELD_W : RW) + 1;

  logic [CW-1:0]  col_r, col_nxt, cx;
  logic [RW-1:0]  row_r, row_nxt, ry;
  logic [PW-1:0]  comp_r, comp_nxt, cc;
  logic [CW1-1:0] tw_sat, col_inc;
  logic [RW1-1:0] th_sat, row_inc;
  logic [PW1-1:0] sc_sat, comp_inc;
  logic           accept;

  logic               s1_v_r;
  logic [XW-1:0]      s1_x_r;
  logic [YW-1:0]      s1_y_r;
  logic [PW-1:0]      s1_c_r;
  logic [FMT_W-1:0]   s1_sf_r;
  logic [VAL_W-1:0]   s1_sv_r;
  logic               keep;
  logic [FIELD_W-1:0] hy;

  always_comb begin
    if (in_tile_width == '0) begin
      tw_sat = CW1'(1);
    end else if (32'(in_tile_width) > MAX_WIDTH) begin
      tw_sat = CW1'(MAX_WIDTH);
    end else begin
      tw_sat = CW1'(in_tile_width);
    end
    if (in_tile_height == '0) begin
      th_sat = RW1'(1);
    end else if (32'(in_tile_height) > MAX_HEIGHT) begin
      th_sat = RW1'(MAX_HEIGHT);
    end else begin
      th_sat = RW1'(in_tile_height);
    end
    if (in_src_components == '0) begin
      sc_sat = PW1'(1);
    end else if (32'(in_src_components) > MAX_COMPONENTS) begin
      sc_sat = PW1'(MAX_COMPONENTS);
    end else begin
      sc_sat = PW1'(in_src_components);
    end
  end

  // A start request restarts the walk at the tile origin for this transaction.
  assign cx = in_start_req ? '0 : col_r;
  assign ry = in_start_req ? '0 : row_r;
  assign cc = in_start_req ? '0 : comp_r;
  assign comp_inc = PW1'(cc) + PW1'(1);
  assign col_inc = CW1'(cx) + CW1'(1);
  assign row_inc = RW1'(ry) + RW1'(1);

  always_comb begin
    comp_nxt = comp_inc[PW-1:0];
    col_nxt = cx;
    row_nxt = ry;
    if (comp_inc >= sc_sat) begin
      comp_nxt = '0;
      col_nxt = col_inc[CW-1:0];
      if (col_inc >= tw_sat) begin
        col_nxt = '0;
        row_nxt = (row_inc >= th_sat) ? '0 : row_inc[RW-1:0];
      end
    end
  end

  assign keep = cfg_i.active && (s1_sf_r <= FMT_INT32) && (s1_x_r < XW'(cfg_i.width))
                && (s1_y_r < YW'(cfg_i.height)) && (3'(s1_c_r) < cfg_i.dcomp);
  assign full = s1_v_r && keep && q_full_i;
  assign accept = push && !full;
  assign q_push_o = s1_v_r && keep && !q_full_i;

  assign hy = cfg_i.height - FIELD_W'(s1_y_r) - FIELD_W'(1);
  always_comb begin
    q_data_o.base = IDX_W'({13'b0, hy} * {13'b0, cfg_i.width});
    q_data_o.x = FIELD_W'(s1_x_r);
    q_data_o.comp = 2'(s1_c_r);
    q_data_o.sfmt = s1_sf_r;
    q_data_o.value = s1_sv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      comp_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        comp_r <= comp_nxt;
      end
      if (!full) begin
        s1_v_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r <= XW'(in_tile_x0) + XW'(cx);
      s1_y_r <= YW'(in_tile_y0) + YW'(ry);
      s1_c_r <= cc;
      s1_sf_r <= in_src_format;
      s1_sv_r <= in_src_value;
    end
  end

endmodule

@@ rtl/twfc_queue.sv @@
// Short queue that decouples the front end from the conversion pipeline.
`timescale 1ns / 1ps

module twfc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  twfc_pkg::q_entry_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output twfc_pkg::q_entry_t data_o,
  output logic               empty_o
);
  import twfc_pkg::*;

  localparam int unsigned AW = $clog2(QDEPTH);
  localparam int unsigned CNTW = $clog2(QDEPTH + 1);

  q_entry_t        mem_r [QDEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign full_o = (count_r == CNTW'(QDEPTH));
  assign empty_o = (count_r == '0);
  assign data_o = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(QDEPTH)) else $error("queue count exceeds depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("pop from an empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> count_r == $past(count_r) + CNTW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

@@ rtl/twfc_back.sv @@
// Back end: element index and four-stage format conversion pipeline.
`timescale 1ns / 1ps

module twfc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  twfc_pkg::cfg_t              cfg_i,
  input  twfc_pkg::q_entry_t          q_data_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [twfc_pkg::IDX_W-1:0]  out_write_index,
  output logic [twfc_pkg::VAL_W-1:0]  out_write_value
);
  import twfc_pkg::*;

  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [3:0]  p;
    logic [10:0] t;
    logic [31:0] r;
    p = '0;
    t = '0;
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == '0) begin
        r = {h[15], 31'b0};
      end else begin
        for (int i = 0; i < 10; i++) begin
          if (h[i]) p = 4'(i);
        end
        t = {1'b0, h[9:0]} << (4'd10 - p);
        r = {h[15], 8'(p) + 8'd103, t[9:0], 13'b0};
      end
    end else if (h[14:10] == 5'h1f) begin
      r = {h[15], 8'hff, h[9:0], 13'b0};
    end else begin
      r = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] float_to_half(input logic [31:0] u);
    logic [7:0]  e;
    logic [22:0] m;
    logic [14:0] h15;
    logic [12:0] rem;
    logic [7:0]  sh;
    logic [24:0] mm, hh, rr, hv;
    logic [15:0] r;
    e = u[30:23];
    m = u[22:0];
    h15 = '0;
    rem = '0;
    sh = '0;
    mm = '0;
    hh = '0;
    rr = '0;
    hv = '0;
    if (e == 8'hff) begin
      if (m == '0) begin
        r = {u[31], 5'h1f, 10'h0};
      end else begin
        r = {u[31], 5'h1f, m[22:13] | {9'b0, (m[22:13] == '0)}};
      end
    end else if (e == 8'd0) begin
      r = {u[31], 15'b0};
    end else if (e > 8'd142) begin
      r = {u[31], 5'h1f, 10'h0};
    end else if (e >= 8'd113) begin
      h15 = {5'(e - 8'd112), m[22:13]};
      rem = m[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && h15[0])) begin
        h15 = h15 + 15'd1;
      end
      r = {u[31], h15};
    end else begin
      sh = 8'd126 - e;
      if (sh > 8'd24) begin
        r = {u[31], 15'b0};
      end else begin
        // Subnormal half: shift in the hidden bit and round to nearest even.
        mm = {2'b01, m};
        hh = mm >> sh;
        rr = mm & ((25'd1 << sh) - 25'd1);
        hv = 25'd1 << (sh - 8'd1);
        if (rr > hv || (rr == hv && hh[0])) begin
          hh = hh + 25'd1;
        end
        r = {u[31], hh[14:0]};
      end
    end
    return r;
  endfunction

  function automatic logic [32:0] round_to_24(input logic [31:0] p);
    logic        up;
    logic [32:0] q;
    if (p[31]) begin
      up = p[7] && ((p[6:0] != '0) || p[8]);
      q = {8'b0, {1'b0, p[31:8]} + 25'(up)} << 8;
    end else if (p[30]) begin
      up = p[6] && ((p[5:0] != '0) || p[7]);
      q = {8'b0, {1'b0, p[30:7]} + 25'(up)} << 7;
    end else begin
      up = p[5] && ((p[4:0] != '0) || p[6]);
      q = {8'b0, {1'b0, p[29:6]} + 25'(up)} << 6;
    end
    return q;
  endfunction

  logic r1, r2, r3, r4;

  // Stage 1: index, raw word, integer magnitude and leading zeros.
  logic               v1_r;
  logic [IDX_W-1:0]   idx1_r;
  logic [VAL_W-1:0]   w1_r;
  logic [FMT_W-1:0]   sf1_r;
  logic               isint1_r, neg1_r;
  logic [31:0]        abs1_r, fb1_r;
  logic [4:0]         lz1_r;
  logic [IDX_W-1:0]   t1, idx1;
  logic [VAL_W-1:0]   w1, iv1, abs1;
  logic [4:0]         lz1;
  logic               isint1;

  // Stage 2: every source as a single-precision pattern.
  logic               v2_r;
  logic [IDX_W-1:0]   idx2_r;
  logic [VAL_W-1:0]   w2_r;
  logic [FMT_W-1:0]   sf2_r;
  logic [31:0]        f2_r;
  logic [31:0]        n2, f2;
  logic [24:0]        m25;
  logic [7:0]         ex2;
  logic               up2;

  // Stage 3: scale product, half and int32 results.
  logic               v3_r;
  logic [IDX_W-1:0]   idx3_r;
  logic [VAL_W-1:0]   w3_r;
  logic [FMT_W-1:0]   sf3_r;
  logic [31:0]        f3_r, prod3_r, i32_3_r;
  logic [15:0]        half3_r;
  logic [31:0]        i32_3;
  logic [30:0]        mag3;
  logic [7:0]         e3c;
  logic               nan3c;

  // Stage 4: 8-bit normalized results and final selection.
  logic               v4_r;
  logic [IDX_W-1:0]   idx4_r;
  logic [VAL_W-1:0]   val4_r;
  logic [32:0]        q4;
  logic [7:0]         e4, sh4, u8, s8, mag8;
  logic [10:0]        tr4;
  logic               nan4;
  logic [VAL_W-1:0]   val4;

  assign r4 = !v4_r || pop;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign q_pop_o = !q_empty_i && r1;

  always_comb begin
    t1 = q_data_i.base + IDX_W'(q_data_i.x);
    unique case (cfg_i.dcomp)
      3'd2: idx1 = t1 << 1;
      3'd3: idx1 = t1 + (t1 << 1);
      3'd4: idx1 = t1 << 2;
      default: idx1 = t1;
    endcase
    idx1 = idx1 + IDX_W'(q_data_i.comp);

    unique case (q_data_i.sfmt)
      FMT_UNORM8: begin
        w1 = {24'b0, q_data_i.value[7:0]};
        iv1 = w1;
        isint1 = 1'b1;
      end
      FMT_SNORM8: begin
        w1 = {24'b0, q_data_i.value[7:0]};
        iv1 = {{24{q_data_i.value[7]}}, q_data_i.value[7:0]};
        isint1 = 1'b1;
      end
      FMT_HALF: begin
        w1 = {16'b0, q_data_i.value[15:0]};
        iv1 = '0;
        isint1 = 1'b0;
      end
      FMT_FLOAT: begin
        w1 = q_data_i.value;
        iv1 = '0;
        isint1 = 1'b0;
      end
      default: begin
        w1 = q_data_i.value;
        iv1 = q_data_i.value;
        isint1 = 1'b1;
      end
    endcase
    abs1 = iv1[31] ? (32'd0 - iv1) : iv1;
    lz1 = '0;
    for (int i = 0; i < 32; i++) begin
      if (abs1[i]) lz1 = 5'(31 - i);
    end
  end

  always_comb begin
    n2 = abs1_r << lz1_r;
    up2 = n2[7] && ((n2[6:0] != '0) || n2[8]);
    m25 = {1'b0, n2[31:8]} + 25'(up2);
    ex2 = 8'd158 - 8'(lz1_r);
    if (m25[24]) begin
      ex2 = ex2 + 8'd1;
    end
    if (!isint1_r) begin
      f2 = fb1_r;
    end else if (abs1_r == '0) begin
      f2 = '0;
    end else begin
      f2 = {neg1_r, ex2, m25[24] ? 23'b0 : m25[22:0]};
    end
  end

  always_comb begin
    e3c = f2_r[30:23];
    nan3c = (e3c == 8'hff) && (f2_r[22:0] != '0);
    mag3 = '0;
    if (nan3c) begin
      i32_3 = '0;
    end else if (e3c >= 8'd158) begin
      i32_3 = f2_r[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (e3c < 8'd127) begin
      i32_3 = '0;
    end else begin
      if (e3c <= 8'd150) begin
        mag3 = 31'({1'b1, f2_r[22:0]} >> (8'd150 - e3c));
      end else begin
        mag3 = 31'({1'b1, f2_r[22:0]}) << (e3c - 8'd150);
      end
      i32_3 = f2_r[31] ? (32'd0 - {1'b0, mag3}) : {1'b0, mag3};
    end
  end

  always_comb begin
    e4 = f3_r[30:23];
    nan4 = (e4 == 8'hff) && (f3_r[22:0] != '0);
    q4 = round_to_24(prod3_r);
    sh4 = 8'd150 - e4;
    tr4 = (sh4 > 8'd32) ? '0 : 11'(q4 >> sh4);

    if (nan4 || f3_r[31] || e4 == 8'd0) begin
      u8 = '0;
    end else if (e4 >= 8'd128 || tr4 >= 11'd255) begin
      u8 = 8'd255;
    end else begin
      u8 = tr4[7:0];
    end

    if (e4 >= 8'd128 || tr4 >= 11'd127) begin
      mag8 = 8'd127;
    end else begin
      mag8 = tr4[7:0];
    end
    if (nan4 || e4 == 8'd0) begin
      s8 = '0;
    end else begin
      s8 = f3_r[31] ? (8'd0 - mag8) : mag8;
    end

    if (sf3_r == cfg_i.dfmt) begin
      val4 = w3_r;
    end else begin
      unique case (cfg_i.dfmt)
        FMT_UNORM8: begin
          val4 = (sf3_r == FMT_SNORM8 || sf3_r == FMT_INT32) ? {24'b0, w3_r[7:0]}
                                                            : {24'b0, u8};
        end
        FMT_SNORM8: begin
          val4 = (sf3_r == FMT_UNORM8 || sf3_r == FMT_INT32) ? {24'b0, w3_r[7:0]}
                                                            : {24'b0, s8};
        end
        FMT_HALF:  val4 = {16'b0, half3_r};
        FMT_FLOAT: val4 = f3_r;
        default: begin
          if (sf3_r == FMT_UNORM8) begin
            val4 = {24'b0, w3_r[7:0]};
          end else if (sf3_r == FMT_SNORM8) begin
            val4 = {{24{w3_r[7]}}, w3_r[7:0]};
          end else begin
            val4 = i32_3_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (r1) v1_r <= !q_empty_i;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      idx1_r <= idx1;
      w1_r <= w1;
      sf1_r <= q_data_i.sfmt;
      isint1_r <= isint1;
      neg1_r <= iv1[31];
      abs1_r <= abs1;
      lz1_r <= lz1;
      fb1_r <= (q_data_i.sfmt == FMT_HALF) ? half_to_float(w1[15:0]) : w1;
    end
    if (r2 && v1_r) begin
      idx2_r <= idx1_r;
      w2_r <= w1_r;
      sf2_r <= sf1_r;
      f2_r <= f2;
    end
    if (r3 && v2_r) begin
      idx3_r <= idx2_r;
      w3_r <= w2_r;
      sf3_r <= sf2_r;
      f3_r <= f2_r;
      prod3_r <= {8'b0, (f2_r[30:23] != 8'd0), f2_r[22:0]}
                 * ((cfg_i.dfmt == FMT_UNORM8) ? 32'd255 : 32'd127);
      half3_r <= float_to_half(f2_r);
      i32_3_r <= i32_3;
    end
    if (r4 && v3_r) begin
      idx4_r <= idx3_r;
      val4_r <= val4;
    end
  end

  assign empty = !v4_r;
  assign out_write_index = idx4_r;
  assign out_write_value = val4_r;

endmodule

@@ rtl/tile_write_format_converter_core.sv @@
// Path: front-end register, queue, then the four conversion stages to the result ports.
// Throughput: one component per cycle while pop keeps up; else the pipeline and queue fill
// and raise full; dropped components leave the front end without entering the queue.
// Reset: synchronous, active low; clears tile position, pipeline and queue, and sets
// buffer size and destination format to zero and destination components to one.
`timescale 1ns / 1ps

module tile_write_format_converter_core #(
  parameter int unsigned MAX_WIDTH = twfc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = twfc_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_COMPONENTS = twfc_pkg::MAX_COMP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_start_req,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_x0,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_y0,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_width,
  input  logic [twfc_pkg::FIELD_W-1:0]  in_tile_height,
  input  logic [twfc_pkg::FMT_W-1:0]    in_src_format,
  input  logic [2:0]                    in_src_components,
  input  logic [twfc_pkg::VAL_W-1:0]    in_src_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [twfc_pkg::IDX_W-1:0]    out_write_index,
  output logic [twfc_pkg::VAL_W-1:0]    out_write_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [twfc_pkg::FIELD_W-1:0]  cfg_data
);
  import twfc_pkg::*;

  logic [FIELD_W-1:0] buf_w_r, buf_h_r;
  logic [FMT_W-1:0]   dfmt_r;
  logic [2:0]         dcomp_r;
  cfg_t               cfg;
  logic               q_push, q_full, q_pop, q_empty;
  q_entry_t           q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_w_r <= '0;
      buf_h_r <= '0;
      dfmt_r <= FMT_UNORM8;
      dcomp_r <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BUF_WIDTH:   buf_w_r <= cfg_data;
        REG_BUF_HEIGHT:  buf_h_r <= cfg_data;
        REG_DEST_FORMAT: dfmt_r <= cfg_data[FMT_W-1:0];
        REG_DEST_COMPS:  dcomp_r <= cfg_data[2:0];
      endcase
    end
  end

  // Register values above the supported maxima saturate.
  always_comb begin
    cfg.width = (32'(buf_w_r) > MAX_WIDTH) ? FIELD_W'(MAX_WIDTH) : buf_w_r;
    cfg.height = (32'(buf_h_r) > MAX_HEIGHT) ? FIELD_W'(MAX_HEIGHT) : buf_h_r;
    cfg.dcomp = (32'(dcomp_r) > MAX_COMPONENTS) ? 3'(MAX_COMPONENTS) : dcomp_r;
    cfg.dfmt = dfmt_r;
    cfg.active = (buf_w_r != '0) && (buf_h_r != '0) && (dfmt_r <= FMT_INT32);
  end

  twfc_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_start_req(in_start_req),
    .in_tile_x0(in_tile_x0),
    .in_tile_y0(in_tile_y0),
    .in_tile_width(in_tile_width),
    .in_tile_height(in_tile_height),
    .in_src_format(in_src_format),
    .in_src_components(in_src_components),
    .in_src_value(in_src_value),
    .cfg_i(cfg),
    .q_push_o(q_push),
    .q_full_i(q_full),
    .q_data_o(q_wdata)
  );

  twfc_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_i(q_push),
    .data_i(q_wdata),
    .full_o(q_full),
    .pop_i(q_pop),
    .data_o(q_rdata),
    .empty_o(q_empty)
  );

  twfc_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_i(cfg),
    .q_data_i(q_rdata),
    .q_empty_i(q_empty),
    .q_pop_o(q_pop),
    .empty(empty),
    .pop(pop),
    .out_write_index(out_write_index),
    .out_write_value(out_write_value)
  );

endmodule
